// ===== hdl/fam_pkg.sv =====
`default_nettype none

package fam_pkg;

  // Storage geometry of the bag.
  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the stream and configuration ports.
  localparam int ACT_W     = 2;
  localparam int IN_VAL_W  = 32;
  localparam int CAP_W     = 7;
  localparam int OUT_CNT_W = 7;
  localparam int OUT_W     = 16;

  // Width that holds both the capacity and the fill count for comparison.
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_COUNT  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Result of one item, handed from the sequencer to the output register.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] fill_count;
    logic                 present;
    logic [OUT_CNT_W-1:0] frequency;
    logic                 accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/fam_ram.sv =====
`default_nettype none

module fam_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fam_ctrl.sv =====
`default_nettype none

module fam_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fam_pkg::action_t              in_action,
  input  wire logic [fam_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic [fam_pkg::CAP_W-1:0]     capacity,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output fam_pkg::result_t                   res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [fam_pkg::CNT_W-1:0]      entries_held;
  fam_pkg::action_t               action_q;
  logic [fam_pkg::VALUE_BITS-1:0] value_q;
  logic [fam_pkg::CNT_W-1:0]      len;
  logic [fam_pkg::ADDR_W-1:0]     last_idx;
  logic [fam_pkg::CNT_W-1:0]      issue_cnt;
  logic [fam_pkg::CNT_W-1:0]      tally;
  logic                           found;
  logic [fam_pkg::ADDR_W-1:0]     found_idx;
  logic [fam_pkg::VALUE_BITS-1:0] last_data;
  logic                           room_q;
  logic                           rd_vld;
  logic [fam_pkg::ADDR_W-1:0]     cmp_idx;

  logic                           room;
  logic                           accept;
  logic                           rd_en;
  logic [fam_pkg::ADDR_W-1:0]     rd_addr;
  logic [fam_pkg::VALUE_BITS-1:0] rd_data;
  logic                           wr_en;
  logic [fam_pkg::ADDR_W-1:0]     wr_addr;
  logic [fam_pkg::VALUE_BITS-1:0] wr_data;
  logic                           fix_slot;
  logic [fam_pkg::CNT_W-1:0]      freq;
  logic [fam_pkg::CNT_W-1:0]      fill;

  // An add has room while the fill is below both the capacity and the depth.
  assign room = (entries_held < fam_pkg::CNT_W'(fam_pkg::DEPTH)) &&
                (fam_pkg::LIM_W'(entries_held) < fam_pkg::LIM_W'(capacity));

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == ST_DONE);

  // The scan reads slots zero to len-1, one per cycle.
  assign rd_en   = (state == ST_SCAN) && (issue_cnt < len);
  assign rd_addr = issue_cnt[fam_pkg::ADDR_W-1:0];

  // A remove that found its value moves the last entry into the hole.
  assign fix_slot = (state == ST_FINAL) && (action_q == fam_pkg::ACT_REMOVE) && found;

  // Writes: an add appends at accept time, a remove patches after its scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entries_held[fam_pkg::ADDR_W-1:0];
    wr_data = in_value;
    if (accept && (in_action == fam_pkg::ACT_ADD) && room) begin
      wr_en = 1'b1;
    end else if (fix_slot) begin
      wr_en   = 1'b1;
      wr_addr = found_idx;
      wr_data = last_data;
    end
  end

  fam_ram #(
    .ADDR_W(fam_pkg::ADDR_W),
    .DATA_W(fam_pkg::VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Frequency and fill after the action, from the tally taken before it.
  always_comb begin
    freq = tally;
    fill = entries_held;
    case (action_q)
      fam_pkg::ACT_ADD: begin
        freq = tally + fam_pkg::CNT_W'(room_q);
      end
      fam_pkg::ACT_REMOVE: begin
        freq = tally - fam_pkg::CNT_W'(found);
        fill = entries_held - fam_pkg::CNT_W'(found);
      end
      fam_pkg::ACT_COUNT: begin
        freq = tally;
      end
      fam_pkg::ACT_CLEAR: begin
        freq = '0;
      end
      default: begin
        freq = tally;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entries_held <= '0;
      rd_vld       <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_action == fam_pkg::ACT_CLEAR) begin
              entries_held <= '0;
            end else if ((in_action == fam_pkg::ACT_ADD) && room) begin
              entries_held <= entries_held + 1'b1;
            end
            if ((in_action == fam_pkg::ACT_CLEAR) || (entries_held == '0)) begin
              state <= ST_FINAL;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && (cmp_idx == last_idx)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (fix_slot) begin
            entries_held <= entries_held - 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item registers, scan counter and match bookkeeping.
  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (accept) begin
      action_q  <= in_action;
      value_q   <= in_value;
      len       <= entries_held;
      last_idx  <= fam_pkg::ADDR_W'(entries_held - 1'b1);
      issue_cnt <= '0;
      tally     <= '0;
      found     <= 1'b0;
      room_q    <= room;
    end
    if (rd_en) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
    if ((state == ST_SCAN) && rd_vld) begin
      last_data <= rd_data;
      if (rd_data == value_q) begin
        tally <= tally + 1'b1;
        if (!found) begin
          found     <= 1'b1;
          found_idx <= cmp_idx;
        end
      end
    end
    if (state == ST_FINAL) begin
      case (action_q)
        fam_pkg::ACT_ADD:    res.accepted <= room_q;
        fam_pkg::ACT_REMOVE: res.accepted <= found;
        default:             res.accepted <= 1'b1;
      endcase
      res.frequency  <= fam_pkg::OUT_CNT_W'(freq);
      res.present    <= (freq != '0);
      res.fill_count <= fam_pkg::OUT_CNT_W'(fill);
    end
  end

  // The fill count never passes the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    entries_held <= fam_pkg::CNT_W'(fam_pkg::DEPTH))
    else $error("fill count above depth");

  // The scan never reads at or beyond the fill taken at accept.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (issue_cnt < len) && (len <= entries_held))
    else $error("scan read outside the filled slots");

  // No slot is written while a scan is in flight.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !wr_en)
    else $error("slot write during scan");

  // A successful remove shrinks the fill by exactly one.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    fix_slot |=> entries_held == $past(entries_held) - 1'b1)
    else $error("remove did not shrink the fill");

endmodule

`default_nettype wire

// ===== hdl/fixed_array_multiset.sv =====
// A result passes from the scan through the final and done states into the output register;
// a clear, or any item on an empty bag, skips the scan and goes straight to the final state.
// A new item is taken only once the sequencer is idle again, after its last result has left.
// The scan reads one stored entry per cycle through the memory's read port.
// Reset (rst, synchronous) empties the bag, sets capacity to 64 and drops any result;
// the slot memory is not cleared, as only slots below the fill count are ever read.
`default_nettype none

module fixed_array_multiset (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [fam_pkg::IN_VAL_W-1:0] s_tdata,  // [31:0] value
  input  wire logic [fam_pkg::ACT_W-1:0]   s_tuser,   // [1:0] action
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [fam_pkg::OUT_W-1:0]   m_tdata,   // [0] accepted, [7:1] frequency,
                                                      // [8] present, [15:9] fill_count
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fam_pkg::CAP_W-1:0]   cfg_data   // [6:0] capacity
);

  logic [fam_pkg::CAP_W-1:0] capacity;
  logic                      res_valid;
  logic                      res_ready;
  fam_pkg::result_t          res;

  // Capacity register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= fam_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  fam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (fam_pkg::action_t'(s_tuser)),
    .in_value  (s_tdata[fam_pkg::VALUE_BITS-1:0]),
    .capacity  (capacity),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: holds a finished beat while the sequencer moves on.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 125;
  localparam int POOL_SIZE     = 6;

  // One row of the directed table; typed rows carry their result by hand.
  typedef struct {
    fam_pkg::action_t act;
    logic [31:0]      val;
    bit               typed;
    fam_pkg::result_t res;
  } dir_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [fam_pkg::IN_VAL_W-1:0]    s_tdata   = '0;   // [31:0] value
  logic [fam_pkg::ACT_W-1:0]       s_tuser   = fam_pkg::ACT_COUNT; // [1:0] action
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [fam_pkg::OUT_W-1:0]       m_tdata;          // [0] accepted, [7:1] frequency,
                                                     // [8] present, [15:9] fill_count
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fam_pkg::CAP_W-1:0]       cfg_data  = fam_pkg::CAP_RESET; // [6:0] capacity

  // Bag model state, kept in step with accepted beats.
  logic [fam_pkg::VALUE_BITS-1:0]  bag_slots [fam_pkg::DEPTH];
  int unsigned                     bag_fill = 0;
  logic [fam_pkg::CAP_W-1:0]       bag_cap  = fam_pkg::CAP_RESET;

  fam_pkg::result_t                results_due [$];
  dir_row_t                        dir_rows [$];
  int                              mismatches   = 0;
  int                              idle_cycles  = 0;
  bit                              s_steady     = 1'b0;
  bit                              r_steady     = 1'b0;

  logic [fam_pkg::CAP_W-1:0]       phase_caps [PHASES] = '{7'd127, 7'd3, 7'd0, 7'd1,
                                                           7'd64, 7'd20, 7'd127, 7'd2};
  int                              phase_add_pct [PHASES] = '{90, 40, 50, 50,
                                                              60, 55, 70, 45};
  logic [31:0]                     value_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_array_multiset dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Apply one action to the bag model and return the result it owes.
  function automatic fam_pkg::result_t bag_apply(input fam_pkg::action_t act,
                                                 input logic [31:0] v);
    int unsigned      lim;
    int unsigned      hits;
    bit               ok;
    fam_pkg::result_t r;
    lim = (bag_cap > fam_pkg::DEPTH) ? fam_pkg::DEPTH : bag_cap;
    ok  = 1'b0;
    case (act)
      fam_pkg::ACT_ADD: begin
        if (bag_fill < lim) begin
          bag_slots[bag_fill] = v;
          bag_fill++;
          ok = 1'b1;
        end
      end
      fam_pkg::ACT_REMOVE: begin
        // The last filled entry moves into the hole left by the first match.
        for (int i = 0; i < bag_fill; i++) begin
          if (bag_slots[i] == v) begin
            bag_fill--;
            bag_slots[i] = bag_slots[bag_fill];
            ok = 1'b1;
            break;
          end
        end
      end
      fam_pkg::ACT_COUNT: ok = 1'b1;
      default: begin
        bag_fill = 0;
        ok = 1'b1;
      end
    endcase
    hits = 0;
    for (int i = 0; i < bag_fill; i++) begin
      if (bag_slots[i] == v) hits++;
    end
    r.accepted   = ok;
    r.frequency  = hits[fam_pkg::OUT_CNT_W-1:0];
    r.present    = (hits != 0);
    r.fill_count = bag_fill[fam_pkg::OUT_CNT_W-1:0];
    return r;
  endfunction

  // Build one directed row and append it to the table.
  task automatic add_row(input fam_pkg::action_t act, input logic [31:0] val,
                         input bit typed, input bit acc,
                         input int freq, input bit pres, input int fill);
    dir_row_t row;
    row.act              = act;
    row.val              = val;
    row.typed            = typed;
    row.res.accepted     = acc;
    row.res.frequency    = freq[fam_pkg::OUT_CNT_W-1:0];
    row.res.present      = pres;
    row.res.fill_count   = fill[fam_pkg::OUT_CNT_W-1:0];
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one item after a random gap, or none while steady, and book its result once accepted.
  task automatic offer_item(input fam_pkg::action_t act, input logic [31:0] v,
                            input bit typed, input fam_pkg::result_t typed_res);
    int               gap;
    fam_pkg::result_t r;
    gap = s_steady ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    r = bag_apply(act, v);
    results_due.insert(results_due.size(), typed ? typed_res : r);
  endtask

  // Stop offering and hold until every booked result has come back.
  task automatic wait_bag_quiet;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [fam_pkg::CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    bag_cap = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input fam_pkg::result_t want,
                               input fam_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected acc=%0d freq=%0d pres=%0d fill=%0d,", what,
               want.accepted, want.frequency, want.present, want.fill_count,
               " got acc=%0d freq=%0d pres=%0d fill=%0d",
               got.accepted, got.frequency, got.present, got.fill_count);
    end
  endtask

  // Result side: a fresh stall is drawn for every beat, or none while steady.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = r_steady ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each result beat with the oldest booked result.
  always @(posedge clk) begin
    fam_pkg::result_t got;
    fam_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = results_due.pop_front();
        if (got.accepted !== want.accepted || got.frequency !== want.frequency ||
            got.present !== want.present || got.fill_count !== want.fill_count) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any beat on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               roll;
    fam_pkg::action_t act;
    logic [31:0]      v;

    // Directed rows: empty bag, extremes, swap-with-last removal, clear.
    add_row(fam_pkg::ACT_COUNT,  32'h0000_0000, 1, 1, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_CLEAR,  32'h0000_0000, 1, 1, 0, 0, 0);
    add_row(fam_pkg::ACT_ADD,    32'h0000_0000, 1, 1, 1, 1, 1);
    add_row(fam_pkg::ACT_ADD,    32'hFFFF_FFFF, 1, 1, 1, 1, 2);
    add_row(fam_pkg::ACT_ADD,    32'hFFFF_FFFF, 1, 1, 2, 1, 3);
    add_row(fam_pkg::ACT_ADD,    32'h8000_0001, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_ADD,    32'h0000_FFFF, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_ADD,    32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_COUNT,  32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'h1234_5678, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_COUNT,  32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'h0000_FFFF, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_COUNT,  32'h8000_0001, 0, 0, 0, 0, 0);
    add_row(fam_pkg::ACT_CLEAR,  32'hAAAA_AAAA, 1, 1, 0, 0, 0);
    add_row(fam_pkg::ACT_COUNT,  32'h5555_5555, 1, 1, 0, 0, 0);
    add_row(fam_pkg::ACT_ADD,    32'h5555_5555, 1, 1, 1, 1, 1);
    add_row(fam_pkg::ACT_REMOVE, 32'h5555_5555, 1, 1, 0, 0, 0);
    add_row(fam_pkg::ACT_REMOVE, 32'h5555_5555, 1, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].act, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end
    wait_bag_quiet();

    // Random phases: each sets a new capacity (above depth, zero, one, below
    // the current fill) and draws values mostly from a small pool so that
    // removes and counts find matches.
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom();
      r_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          s_steady = ($urandom_range(0, 2) == 0);
          r_steady = ($urandom_range(0, 2) == 0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          act = fam_pkg::ACT_CLEAR;
        end else if (roll < 2 + phase_add_pct[p]) begin
          act = fam_pkg::ACT_ADD;
        end else if ($urandom_range(0, 2) != 0) begin
          act = fam_pkg::ACT_REMOVE;
        end else begin
          act = fam_pkg::ACT_COUNT;
        end
        v = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : $urandom();
        offer_item(act, v, 1'b0, '0);
      end
      wait_bag_quiet();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/fam_pkg.sv
hdl/fam_ram.sv
hdl/fam_ctrl.sv
hdl/fixed_array_multiset.sv
tb/tb_top.sv
